### rtl/bec_pkg.sv
// Shared constants, types and the per-byte decode function of the backslash escape codec.
`default_nettype none

package bec_pkg;

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_LOWER_N   = 8'h6E;
    localparam logic [7:0] CH_LOWER_R   = 8'h72;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_RETURN    = 8'h0D;

    localparam logic DIR_ESCAPE   = 1'b0;
    localparam logic DIR_UNESCAPE = 1'b1;

    // One output byte with its two marks.
    typedef struct packed {
        logic [7:0] data;
        logic       run_end;
        logic       string_end;
    } bec_result_t;

    // Everything one input byte produces.
    typedef struct packed {
        logic [1:0]  count;
        bec_result_t first;
        bec_result_t second;
        logic        pending_next;
    } bec_decode_t;

    function automatic bec_decode_t bec_decode(
        input logic       direction,
        input logic       pending,
        input logic [7:0] in_byte,
        input logic       last_byte
    );
        bec_decode_t d;
        d.count        = 2'd1;
        d.first        = '{data: in_byte, run_end: 1'b1, string_end: last_byte};
        d.second       = '{data: in_byte, run_end: 1'b1, string_end: last_byte};
        d.pending_next = 1'b0;
        if (direction == DIR_ESCAPE) begin
            if (in_byte == CH_BACKSLASH || in_byte == CH_NEWLINE || in_byte == CH_RETURN) begin
                d.count       = 2'd2;
                d.first       = '{data: CH_BACKSLASH, run_end: 1'b0, string_end: 1'b0};
                if (in_byte == CH_NEWLINE) begin
                    d.second.data = CH_LOWER_N;
                end else if (in_byte == CH_RETURN) begin
                    d.second.data = CH_LOWER_R;
                end else begin
                    d.second.data = CH_BACKSLASH;
                end
            end
        end else if (pending) begin
            if (in_byte == CH_BACKSLASH) begin
                d.first.data = CH_BACKSLASH;
            end else if (in_byte == CH_LOWER_N) begin
                d.first.data = CH_NEWLINE;
            end else if (in_byte == CH_LOWER_R) begin
                d.first.data = CH_RETURN;
            end else begin
                // Unknown escape: the held backslash goes out ahead of the byte.
                d.count = 2'd2;
                d.first = '{data: CH_BACKSLASH, run_end: 1'b0, string_end: 1'b0};
            end
        end else if (in_byte == CH_BACKSLASH && !last_byte) begin
            d.count        = 2'd0;
            d.pending_next = 1'b1;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

### rtl/backslash_escape_codec.sv
// Top level of the backslash escape codec: input register, decode and output register.
`default_nettype none

// Backslash escape codec for byte streams.
// The slave channel (s_) carries one character per request, with s_tlast marking
// the final character of a string. The master channel (m_) carries one output
// byte per request; m_tlast marks the last byte caused by an input character and
// m_tuser marks the final byte of the whole string.
// cfg_wr_en/cfg_wr_data write the direction register (0 escapes, 1 unescapes);
// every write also drops a held backslash. Write only while the block is idle.
// An accepted character lands in the input register; its first output byte is
// then loaded into the output register once that register is free. A character
// that yields one byte retires as that byte is loaded and one that yields none
// retires at once, so such characters stream at one per cycle while the receiver
// keeps up. A character that yields two bytes stays in the input register until
// both are loaded, since the single output register takes one byte per cycle
// when not stalled. A backslash held in unescape mode yields no byte.
// When the receiver stalls, the output register holds its byte and a character
// with bytes to send waits in the input register, s_tready low, until the stall clears.
// Reset (synchronous, active low) empties both registers, clears the held
// backslash and sets the escape direction.
module backslash_escape_codec (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_wr_en,
    input  wire logic       cfg_wr_data,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] in_byte
    input  wire logic       s_tlast,   // last_byte
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_byte
    output logic            m_tlast,   // run_end
    output logic            m_tuser    // [0] string_end
);

    logic                 direction_reg;
    logic                 pending_reg;
    logic                 pending_next;

    // Input register: the character being worked on.
    logic                 in_valid_reg;
    logic [7:0]           in_byte_reg;
    logic                 in_last_reg;

    // Which of the character's output bytes goes out next.
    logic                 sel_reg;
    logic                 sel_next;

    // Output register.
    logic                 out_valid_reg;
    bec_pkg::bec_result_t out_reg;

    bec_pkg::bec_decode_t dec;
    bec_pkg::bec_result_t chosen;
    logic                 out_free;
    logic                 out_load;
    logic                 retire;
    logic                 accept;

    always_comb begin
        dec = bec_pkg::bec_decode(direction_reg, pending_reg, in_byte_reg, in_last_reg);
    end

    assign chosen   = sel_reg ? dec.second : dec.first;
    assign out_free = !out_valid_reg || m_tready;

    // A character that yields nothing retires without touching the output side;
    // otherwise each free output slot takes one of its bytes, the last one retiring it.
    always_comb begin
        out_load = 1'b0;
        retire   = 1'b0;
        sel_next = sel_reg;
        if (in_valid_reg) begin
            if (dec.count == 2'd0) begin
                retire = 1'b1;
            end else if (out_free) begin
                out_load = 1'b1;
                if (sel_reg || dec.count == 2'd1) begin
                    retire   = 1'b1;
                    sel_next = 1'b0;
                end else begin
                    sel_next = 1'b1;
                end
            end
        end
    end

    assign s_tready = !in_valid_reg || retire;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        pending_next = pending_reg;
        if (cfg_wr_en) begin
            pending_next = 1'b0;
        end else if (retire) begin
            pending_next = dec.pending_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            direction_reg <= bec_pkg::DIR_ESCAPE;
            pending_reg   <= 1'b0;
            in_valid_reg  <= 1'b0;
            sel_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                direction_reg <= cfg_wr_data;
            end
            pending_reg <= pending_next;
            sel_reg     <= sel_next;
            if (accept) begin
                in_valid_reg <= 1'b1;
            end else if (retire) begin
                in_valid_reg <= 1'b0;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (accept) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (out_load) begin
            out_reg <= chosen;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.data;
    assign m_tlast  = out_reg.run_end;
    assign m_tuser  = out_reg.string_end;

endmodule

`default_nettype wire
